/* src/suffix_automaton_substring_match_defines.svh */
// Assertion macros shared by the suffix automaton matcher RTL.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in the using scope.
`ifndef SUFFIX_AUTOMATON_SUBSTRING_MATCH_DEFINES_SVH
`define SUFFIX_AUTOMATON_SUBSTRING_MATCH_DEFINES_SVH

// Checks a property on every clock edge outside reset.
`define SAM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define SAM_ASSERT_NEXT(lbl, pre, post, msg) \
    `SAM_ASSERT(lbl, (pre) |=> (post), msg)

`endif

/* src/sam_pkg.sv */
// Shared constants, types and helpers for the suffix automaton matcher.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sam_pkg;

    localparam int MAX_TEXT  = 1024;
    localparam int MAX_NODES = 2048;
    localparam int ALPHABET  = 26;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int LEN_W  = $clog2(MAX_TEXT + 1);
    localparam int SYM_W  = 5;
    localparam int OP_W   = 2;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_MATCH  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    typedef logic [ALPHABET-1:0][NODE_W-1:0] t_row;

    // One bit per datapath step; bits raised together always touch different registers.
    typedef struct packed {
        logic clr;
        logic take;
        logic res_plain;
        logic res_full;
        logic ap_start;
        logic rd_p;
        logic ap_walk;
        logic ap_split;
        logic ap_link_q;
        logic ap_link_np;
        logic ap_redirect;
        logic ap_commit;
        logic m_start;
        logic m_fast;
        logic m_step;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            sym_bad;
        logic            full;
        logic            edge_hit;
        logic            p_is_root;
        logic            q_solid;
        logic            redirect_hit;
    } t_dp_sts;

    // Length plus one, held at the longest text length.
    function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] x);
        logic [LEN_W-1:0] r;
        if (x >= LEN_W'(MAX_TEXT)) begin
            r = LEN_W'(MAX_TEXT);
        end else begin
            r = x + LEN_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/sam_ctrl.sv */
// Sequencer for the suffix automaton matcher: one state per memory step.
// Depends on sam_pkg for the command and status structs and op codes.
`timescale 1ns / 1ps
`default_nettype none

module sam_ctrl
    import sam_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire logic    i_out_free,
    output logic         o_emit,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    localparam logic [3:0] ST_INIT   = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_DISP   = 4'd2;
    localparam logic [3:0] ST_AP_RD  = 4'd3;
    localparam logic [3:0] ST_AP_CHK = 4'd4;
    localparam logic [3:0] ST_AP_Q   = 4'd5;
    localparam logic [3:0] ST_CL2    = 4'd6;
    localparam logic [3:0] ST_CL3    = 4'd7;
    localparam logic [3:0] ST_RD2    = 4'd8;
    localparam logic [3:0] ST_CHK2   = 4'd9;
    localparam logic [3:0] ST_AP_END = 4'd10;
    localparam logic [3:0] ST_M_RD   = 4'd11;
    localparam logic [3:0] ST_M_CHK  = 4'd12;
    localparam logic [3:0] ST_DONE   = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_emit     = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.clr = 1'b1;
                n_state   = ST_IDLE;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = ST_DISP;
                end
            end
            ST_DISP: begin
                unique case (i_sts.op)
                    OP_APPEND: begin
                        if (i_sts.sym_bad) begin
                            o_cmd.res_plain = 1'b1;
                            n_state         = ST_DONE;
                        end else if (i_sts.full) begin
                            o_cmd.res_full = 1'b1;
                            n_state        = ST_DONE;
                        end else begin
                            o_cmd.ap_start = 1'b1;
                            n_state        = ST_AP_RD;
                        end
                    end
                    OP_MATCH: begin
                        if (i_sts.sym_bad) begin
                            o_cmd.m_fast = 1'b1;
                            n_state      = ST_DONE;
                        end else begin
                            o_cmd.m_start = 1'b1;
                            n_state       = ST_M_RD;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.clr = 1'b1;
                        n_state   = ST_DONE;
                    end
                    default: begin
                        o_cmd.res_plain = 1'b1;
                        n_state         = ST_DONE;
                    end
                endcase
            end
            ST_AP_RD: begin
                o_cmd.rd_p = 1'b1;
                n_state    = ST_AP_CHK;
            end
            ST_AP_CHK: begin
                o_cmd.ap_walk = 1'b1;
                if (i_sts.edge_hit) begin
                    n_state = ST_AP_Q;
                end else if (i_sts.p_is_root) begin
                    n_state = ST_AP_END;
                end else begin
                    n_state = ST_AP_RD;
                end
            end
            ST_AP_Q: begin
                o_cmd.ap_split = 1'b1;
                n_state = i_sts.q_solid ? ST_AP_END : ST_CL2;
            end
            ST_CL2: begin
                o_cmd.ap_link_q = 1'b1;
                n_state         = ST_CL3;
            end
            ST_CL3: begin
                o_cmd.ap_link_np = 1'b1;
                o_cmd.rd_p       = 1'b1;
                n_state          = ST_CHK2;
            end
            ST_RD2: begin
                o_cmd.rd_p = 1'b1;
                n_state    = ST_CHK2;
            end
            ST_CHK2: begin
                o_cmd.ap_redirect = 1'b1;
                n_state = (i_sts.redirect_hit && !i_sts.p_is_root) ? ST_RD2 : ST_AP_END;
            end
            ST_AP_END: begin
                o_cmd.ap_commit = 1'b1;
                o_cmd.res_plain = 1'b1;
                n_state         = ST_DONE;
            end
            ST_M_RD: begin
                o_cmd.rd_p = 1'b1;
                n_state    = ST_M_CHK;
            end
            ST_M_CHK: begin
                o_cmd.m_step = 1'b1;
                n_state = (i_sts.edge_hit || i_sts.p_is_root) ? ST_DONE : ST_M_RD;
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_emit  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/sam_dp.sv */
// Datapath of the suffix automaton matcher: transition, link and length memories
// plus the walk pointers and match state. Depends on sam_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sam_dp
    import sam_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_dp_cmd          i_cmd,
    input  wire logic [OP_W-1:0]  i_op,
    input  wire logic [SYM_W-1:0] i_symbol,
    output t_dp_sts               o_sts,
    output logic [LEN_W-1:0]      o_match_len,
    output logic [LEN_W-1:0]      o_best_len,
    output logic                  o_status
);

    // Rows hold all outgoing edges of one node; a zero entry means no edge.
    t_row             r_trans_mem [MAX_NODES];
    logic [NODE_W-1:0] r_link_mem [MAX_NODES];
    logic [LEN_W-1:0]  r_len_mem  [MAX_NODES];

    t_row              r_row_q;
    logic [NODE_W-1:0] r_link_q;
    logic [LEN_W-1:0]  r_len_q;
    logic              r_rd_root;

    logic [OP_W-1:0]   r_op;
    logic [SYM_W-1:0]  r_sym;
    logic [NODE_W-1:0] r_p;
    logic [NODE_W-1:0] r_np;
    logic [NODE_W-1:0] r_q;
    logic [NODE_W-1:0] r_nq;
    logic [LEN_W-1:0]  r_lenp;
    logic [NODE_W-1:0] r_last;
    logic [LEN_W-1:0]  r_last_len;
    logic [NODE_W-1:0] r_count;
    logic [NODE_W-1:0] r_match_node;
    logic [LEN_W-1:0]  r_cur_len;
    logic [LEN_W-1:0]  r_best;
    logic              r_first;
    logic [LEN_W-1:0]  r_res_match;
    logic [LEN_W-1:0]  r_res_best;
    logic              r_res_status;

    logic [NODE_W-1:0] edge_tgt;
    logic [LEN_W-1:0]  len_val;
    logic [NODE_W-1:0] count_inc;
    logic [LEN_W-1:0]  step_len;

    logic              rd_en;
    logic [NODE_W-1:0] rd_addr;

    logic                row_we;
    logic [NODE_W-1:0]   row_waddr;
    logic [ALPHABET-1:0] lane_we;
    t_row                row_wdata;

    logic              link_we;
    logic [NODE_W-1:0] link_waddr;
    logic [NODE_W-1:0] link_wdata;

    logic              len_we;
    logic [NODE_W-1:0] len_waddr;
    logic [LEN_W-1:0]  len_wdata;

    assign edge_tgt  = r_row_q[r_sym];
    assign len_val   = r_rd_root ? '0 : r_len_q;
    assign count_inc = r_count + NODE_W'(1);
    assign step_len  = r_first ? sat_inc(r_cur_len) : sat_inc(len_val);

    always_comb begin
        o_sts.op           = r_op;
        o_sts.sym_bad      = (r_sym >= SYM_W'(ALPHABET));
        o_sts.full         = (r_last_len >= LEN_W'(MAX_TEXT))
                          || (({1'b0, r_count} + (NODE_W+1)'(3)) > (NODE_W+1)'(MAX_NODES));
        o_sts.edge_hit     = (edge_tgt != '0);
        o_sts.p_is_root    = (r_p == '0);
        o_sts.q_solid      = ({1'b0, len_val} == ({1'b0, r_lenp} + (LEN_W+1)'(1)));
        o_sts.redirect_hit = (edge_tgt == r_q);
    end

    // Memory read port: walk pointer, or the edge target found by an append.
    always_comb begin
        rd_en   = i_cmd.rd_p || (i_cmd.ap_walk && o_sts.edge_hit);
        rd_addr = i_cmd.rd_p ? r_p : edge_tgt;
    end

    always_comb begin
        row_we    = 1'b0;
        row_waddr = r_p;
        lane_we   = '0;
        row_wdata = '0;
        link_we    = 1'b0;
        link_waddr = r_np;
        link_wdata = '0;
        len_we     = 1'b0;
        len_waddr  = count_inc;
        len_wdata  = r_lenp + LEN_W'(1);
        if (i_cmd.clr) begin
            row_we    = 1'b1;
            row_waddr = '0;
            lane_we   = '1;
        end
        if (i_cmd.ap_start) begin
            row_we    = 1'b1;
            row_waddr = count_inc;
            lane_we   = '1;
            len_we    = 1'b1;
            len_wdata = r_last_len + LEN_W'(1);
        end
        if (i_cmd.ap_walk && !o_sts.edge_hit) begin
            row_we         = 1'b1;
            lane_we[r_sym] = 1'b1;
            for (int k = 0; k < ALPHABET; k++) begin
                row_wdata[k] = r_np;
            end
            if (o_sts.p_is_root) begin
                link_we = 1'b1;
            end
        end
        if (i_cmd.ap_split) begin
            if (o_sts.q_solid) begin
                link_we    = 1'b1;
                link_wdata = r_q;
            end else begin
                row_we     = 1'b1;
                row_waddr  = count_inc;
                lane_we    = '1;
                row_wdata  = r_row_q;
                len_we     = 1'b1;
                link_we    = 1'b1;
                link_waddr = count_inc;
                link_wdata = r_link_q;
            end
        end
        if (i_cmd.ap_link_q) begin
            link_we    = 1'b1;
            link_waddr = r_q;
            link_wdata = r_nq;
        end
        if (i_cmd.ap_link_np) begin
            link_we    = 1'b1;
            link_wdata = r_nq;
        end
        if (i_cmd.ap_redirect && o_sts.redirect_hit) begin
            row_we         = 1'b1;
            lane_we[r_sym] = 1'b1;
            for (int k = 0; k < ALPHABET; k++) begin
                row_wdata[k] = r_nq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (row_we) begin
            for (int k = 0; k < ALPHABET; k++) begin
                if (lane_we[k]) begin
                    r_trans_mem[row_waddr][k] <= row_wdata[k];
                end
            end
        end
        if (link_we) begin
            r_link_mem[link_waddr] <= link_wdata;
        end
        if (len_we) begin
            r_len_mem[len_waddr] <= len_wdata;
        end
        if (rd_en) begin
            r_row_q   <= r_trans_mem[rd_addr];
            r_link_q  <= r_link_mem[rd_addr];
            r_len_q   <= r_len_mem[rd_addr];
            r_rd_root <= (rd_addr == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op  <= i_op;
            r_sym <= i_symbol;
        end
        if (i_cmd.clr) begin
            r_last       <= '0;
            r_last_len   <= '0;
            r_count      <= '0;
            r_match_node <= '0;
            r_cur_len    <= '0;
            r_best       <= '0;
            r_res_match  <= '0;
            r_res_best   <= '0;
            r_res_status <= 1'b0;
        end
        if (i_cmd.res_plain) begin
            r_res_match  <= '0;
            r_res_best   <= r_best;
            r_res_status <= 1'b0;
        end
        if (i_cmd.res_full) begin
            r_res_match  <= '0;
            r_res_best   <= r_best;
            r_res_status <= 1'b1;
        end
        if (i_cmd.ap_start) begin
            r_p     <= r_last;
            r_np    <= count_inc;
            r_count <= count_inc;
        end
        if (i_cmd.ap_walk) begin
            if (o_sts.edge_hit) begin
                r_q    <= edge_tgt;
                r_lenp <= len_val;
            end else begin
                r_p <= r_link_q;
            end
        end
        if (i_cmd.ap_split && !o_sts.q_solid) begin
            r_nq    <= count_inc;
            r_count <= count_inc;
        end
        if (i_cmd.ap_redirect) begin
            r_p <= r_link_q;
        end
        if (i_cmd.ap_commit) begin
            r_last     <= r_np;
            r_last_len <= r_last_len + LEN_W'(1);
        end
        if (i_cmd.m_start) begin
            r_p     <= r_match_node;
            r_first <= 1'b1;
        end
        if (i_cmd.m_fast) begin
            r_match_node <= '0;
            r_cur_len    <= '0;
            r_res_match  <= '0;
            r_res_best   <= r_best;
            r_res_status <= 1'b0;
        end
        if (i_cmd.m_step) begin
            if (o_sts.edge_hit) begin
                r_match_node <= edge_tgt;
                r_cur_len    <= step_len;
                r_res_match  <= step_len;
                r_res_best   <= (step_len > r_best) ? step_len : r_best;
                r_best       <= (step_len > r_best) ? step_len : r_best;
                r_res_status <= 1'b0;
            end else if (o_sts.p_is_root) begin
                r_match_node <= '0;
                r_cur_len    <= '0;
                r_res_match  <= '0;
                r_res_best   <= r_best;
                r_res_status <= 1'b0;
            end else begin
                r_p     <= r_link_q;
                r_first <= 1'b0;
            end
        end
    end

    assign o_match_len = r_res_match;
    assign o_best_len  = r_res_best;
    assign o_status    = r_res_status;

endmodule

`default_nettype wire

/* src/suffix_automaton_substring_match.sv */
// Channel   Dir  Payload                                       Flow
// s_axis    in   tdata: symbol[4:0], zero pad                  one item in flight
//                tuser: op[1:0]
// m_axis    out  tdata: match_len[10:0], best_len[21:11], pad; one result per item
//                tuser: status
//
// Every memory step is an address state followed by a state that uses the registered
// data. A clear, an ignored item or the unused op goes from dispatch to the result, and
// a match reads and checks each node tried on its suffix-link walk (at least one).
// An append reads and checks each node on its walk, then a split step when the walk
// ends on an edge, and link steps plus a redirect walk when that edge forces a clone.
// Reset is synchronous and active low; an init state after reset clears the root row
// before the first transfer is taken. A result waits in the output register while
// the master side stalls, and the next input is taken as soon as it is loaded there.
`timescale 1ns / 1ps
`default_nettype none
`include "suffix_automaton_substring_match_defines.svh"

module suffix_automaton_substring_match
    import sam_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // symbol[4:0], bits 7:5 zero pad
    input  wire logic [1:0]  i_s_axis_tuser,   // op[1:0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,   // match_len[10:0], best_len[21:11], zero pad
    output logic             o_m_axis_tuser    // status: automaton full, append ignored
);

    t_dp_cmd          cmd;
    t_dp_sts          sts;
    logic             emit;
    logic             out_free;
    logic [LEN_W-1:0] dp_match;
    logic [LEN_W-1:0] dp_best;
    logic             dp_status;

    // Output register: holds one finished result until the master side takes it.
    logic             r_m_valid;
    logic [LEN_W-1:0] r_m_match;
    logic [LEN_W-1:0] r_m_best;
    logic             r_m_status;

    assign out_free = !r_m_valid || i_m_axis_tready;

    sam_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_out_free (out_free),
        .o_emit     (emit),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sam_dp u_dp (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_op        (i_s_axis_tuser),
        .i_symbol    (i_s_axis_tdata[SYM_W-1:0]),
        .o_sts       (sts),
        .o_match_len (dp_match),
        .o_best_len  (dp_best),
        .o_status    (dp_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (emit) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_m_match  <= dp_match;
            r_m_best   <= dp_best;
            r_m_status <= dp_status;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {2'b00, r_m_best, r_m_match};
    assign o_m_axis_tuser  = r_m_status;

    // The sequencer leaves idle on every accepted transfer.
    `SAM_ASSERT_NEXT(a_busy_after_take, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "input taken while an item is in work")
    // The running best never trails the current match length.
    `SAM_ASSERT(a_best_covers_match, r_m_valid |-> (r_m_best >= r_m_match), "best length below match length")
    // A refused append never carries a match length.
    `SAM_ASSERT(a_full_no_match, (r_m_valid && r_m_status) |-> (r_m_match == '0), "full status with nonzero match length")

endmodule

`default_nettype wire
